// ===== src/mlslu_pkg.sv =====
`timescale 1ns / 1ps
package mlslu_pkg;

  localparam logic [2:0] OP_LB  = 3'd0;
  localparam logic [2:0] OP_LBU = 3'd1;
  localparam logic [2:0] OP_LH  = 3'd2;
  localparam logic [2:0] OP_LHU = 3'd3;
  localparam logic [2:0] OP_LW  = 3'd4;
  localparam logic [2:0] OP_SB  = 3'd5;
  localparam logic [2:0] OP_SH  = 3'd6;
  localparam logic [2:0] OP_SW  = 3'd7;

  localparam logic [2:0] RG_NONE = 3'd0;
  localparam logic [2:0] RG_INST = 3'd1;
  localparam logic [2:0] RG_DATA = 3'd2;
  localparam logic [2:0] RG_GETC = 3'd3;
  localparam logic [2:0] RG_PUTC = 3'd4;

  localparam logic [31:0] INST_START = 32'h1000_0000;
  localparam logic [31:0] DATA_START = 32'h2000_0000;
  localparam logic [31:0] GETC_START = 32'h3000_0000;
  localparam logic [31:0] PUTC_START = 32'h3000_0004;
  localparam logic [31:0] INST_SIZE  = 32'h0100_0000;
  localparam logic [31:0] DATA_SIZE  = 32'h0400_0000;
  localparam logic [31:0] WORD_MASK  = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF_EXT   = 32'hFFFF_0000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [31:0] store_data;
    logic [31:0] memory_word;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [25:0] region_offset;
    logic [31:0] load_value;
    logic [31:0] write_word;
    logic        write_enable;
    logic        fault;
  } out_req_t;

  // Region decode result handed to the lane logic
  typedef struct packed {
    logic [2:0]  region;
    logic [25:0] offset;
  } region_dec_t;

endpackage

// ===== src/mlslu_decode.sv =====
`timescale 1ns / 1ps
module mlslu_decode
  import mlslu_pkg::*;
(
  input  logic [2:0]  operation,
  input  logic [31:0] address,
  output region_dec_t dec
);

  logic [31:0] al;
  logic        is_store;
  logic        in_inst;
  logic        in_data;
  logic [31:0] inst_off;
  logic [31:0] data_off;

  assign al       = address & (WORD_MASK << 2);
  assign is_store = (operation == OP_SB) || (operation == OP_SH) || (operation == OP_SW);
  assign inst_off = al - INST_START;
  assign data_off = al - DATA_START;
  assign in_inst  = (al >= INST_START) && (inst_off < INST_SIZE);
  assign in_data  = (al >= DATA_START) && (data_off < DATA_SIZE);

  always_comb begin
    dec.region = RG_NONE;
    dec.offset = '0;
    if (is_store) begin
      if (in_data) begin
        dec.region = RG_DATA;
        dec.offset = data_off[25:0];
      end else if (al == PUTC_START) begin
        dec.region = RG_PUTC;
      end
    end else begin
      if (in_inst) begin
        dec.region = RG_INST;
        dec.offset = inst_off[25:0];
      end else if (in_data) begin
        dec.region = RG_DATA;
        dec.offset = data_off[25:0];
      end else if (al == GETC_START) begin
        dec.region = RG_GETC;
      end else if (al == 32'd0) begin
        dec.region = RG_INST;
      end
    end
  end

endmodule

// ===== src/mlslu_lane.sv =====
`timescale 1ns / 1ps
module mlslu_lane
  import mlslu_pkg::*;
(
  input  in_req_t     req,
  input  region_dec_t dec,
  output out_req_t    res
);

  logic [1:0]  lane;
  logic [4:0]  be_sh;   // big-endian lane shift
  logic [4:0]  le_sh;   // little-endian lane shift
  logic [7:0]  ld_byte;
  logic [15:0] ld_half;
  logic [7:0]  st_byte;
  logic [15:0] st_half;
  logic        bad;

  assign lane    = req.address[1:0];
  assign be_sh   = {~lane, 3'b000};
  assign le_sh   = {lane, 3'b000};
  assign ld_byte = 8'(req.memory_word >> be_sh);
  assign ld_half = lane[1] ? req.memory_word[15:0] : req.memory_word[31:16];
  assign st_byte = req.store_data[7:0];
  assign st_half = req.store_data[15:0];
  assign bad     = (dec.region == RG_NONE);

  always_comb begin
    res.region        = dec.region;
    res.region_offset = dec.offset;
    res.load_value    = '0;
    res.write_word    = '0;
    res.write_enable  = 1'b0;
    res.fault         = bad;
    if (!bad) begin
      unique case (req.operation)
        OP_LB:  res.load_value = {{24{ld_byte[7]}}, ld_byte};
        OP_LBU: res.load_value = {24'd0, ld_byte};
        OP_LH, OP_LHU: begin
          if (lane[0]) begin
            res.fault = 1'b1;
          end else if (req.operation == OP_LH) begin
            res.load_value = {{16{ld_half[15]}}, ld_half};
          end else begin
            res.load_value = {16'd0, ld_half};
          end
        end
        OP_LW: begin
          if (lane != 2'd0) res.fault = 1'b1;
          else res.load_value = req.memory_word;
        end
        OP_SB: begin
          res.write_enable = 1'b1;
          if (dec.region == RG_PUTC) begin
            res.write_word = {24'd0, st_byte} << le_sh;
          end else begin
            res.write_word = (req.memory_word & ~(32'h0000_00FF << be_sh))
                           | ({24'd0, st_byte} << be_sh);
          end
        end
        OP_SH: begin
          if (lane[0]) begin
            res.fault = 1'b1;
          end else begin
            res.write_enable = 1'b1;
            if (dec.region == RG_PUTC) begin
              res.write_word = {16'd0, st_half} << le_sh;
            end else if (!lane[1]) begin
              res.write_word = {st_half, req.memory_word[15:0]};
            end else begin
              res.write_word = (req.memory_word & HALF_EXT) | {16'd0, st_half};
            end
          end
        end
        OP_SW: begin
          if (lane != 2'd0) begin
            res.fault = 1'b1;
          end else begin
            res.write_enable = 1'b1;
            res.write_word   = req.store_data;
          end
        end
        default: res.fault = 1'b1;
      endcase
    end
  end

endmodule

// ===== src/mips_load_store_lane_unit.sv =====
`timescale 1ns / 1ps
// An accepted request is held in the input register, and its result then in the
// result register that drives out_valid. Throughput: one request per cycle while
// out_ready holds high; the input register and the result register each hold one
// request, and decode plus lane logic sit between them. Reset: synchronous, active
// low rst_n clears both valid flags; payload registers are not reset.
module mips_load_store_lane_unit
  import mlslu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  // Input stage: holds the request while decode and lane logic work on it
  logic        s1_valid_r, s1_valid_nxt;
  in_req_t     s1_data_r;
  // Result stage: holds a finished result until the consumer takes it
  logic        out_valid_r, out_valid_nxt;
  out_req_t    out_data_r;

  region_dec_t dec;
  out_req_t    res;
  logic        out_free;
  logic        s1_free;

  mlslu_decode u_decode (
    .operation (s1_data_r.operation),
    .address   (s1_data_r.address),
    .dec       (dec)
  );

  mlslu_lane u_lane (
    .req (s1_data_r),
    .dec (dec),
    .res (res)
  );

  // Result register can load when empty or when its result leaves this cycle
  assign out_free = !out_valid_r || out_ready;
  // Input register can load when empty or when its request moves to the result stage
  assign s1_free  = !s1_valid_r || out_free;
  assign in_ready = s1_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt  = s1_free ? in_valid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance payloads; hold them while the stage downstream is full
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) s1_data_r <= in_data;
    if (out_free && s1_valid_r) out_data_r <= res;
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid flags not cleared by reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted request lost in input stage");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fault) |->
      (!out_data_r.write_enable && out_data_r.load_value == 32'd0))
    else $error("faulted request produced data or a write");

  a_none_faults: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.region == RG_NONE) |->
      (out_data_r.fault && out_data_r.region_offset == 26'd0))
    else $error("bad region without fault");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.write_enable) |-> out_data_r.write_word == 32'd0)
    else $error("write word set without write enable");

endmodule

// ===== verif/tb_mips_load_store_lane_unit.sv =====
`timescale 1ns / 1ps
module tb_mips_load_store_lane_unit;
  import mlslu_pkg::*;

  // Both port windows (getc and putc) are one word wide.
  localparam logic [31:0] PORT_BYTES = 32'd4;
  localparam int ACCESSES_PER_PHASE = 375;
  localparam int NUM_PHASES = 4;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  // Two register stages inside the block, plus margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  // Predicts one result per access and matches results in order.
  class access_scoreboard;
    out_req_t pending_results[$];
    int mismatches;
    int unexpected;
    int results_checked;
    int requests_noted;
    int loads_noted;
    int stores_noted;
    int faults_noted;

    function new();
      mismatches = 0;
      unexpected = 0;
      results_checked = 0;
      requests_noted = 0;
      loads_noted = 0;
      stores_noted = 0;
      faults_noted = 0;
    endfunction

    function region_dec_t decode_load_region(logic [31:0] aligned);
      region_dec_t dec;
      dec = '0;
      if (aligned >= INST_START && aligned - INST_START < INST_SIZE) begin
        dec.region = RG_INST;
        dec.offset = 26'(aligned - INST_START);
      end else if (aligned >= DATA_START && aligned - DATA_START < DATA_SIZE) begin
        dec.region = RG_DATA;
        dec.offset = 26'(aligned - DATA_START);
      end else if (aligned >= GETC_START && aligned - GETC_START < PORT_BYTES) begin
        dec.region = RG_GETC;
      end else if (aligned == 32'd0) begin
        // address zero reads as the first instruction word
        dec.region = RG_INST;
      end
      return dec;
    endfunction

    function region_dec_t decode_store_region(logic [31:0] aligned);
      region_dec_t dec;
      dec = '0;
      if (aligned >= DATA_START && aligned - DATA_START < DATA_SIZE) begin
        dec.region = RG_DATA;
        dec.offset = 26'(aligned - DATA_START);
      end else if (aligned >= PUTC_START && aligned - PUTC_START < PORT_BYTES) begin
        dec.region = RG_PUTC;
      end
      return dec;
    endfunction

    function out_req_t predict_access(in_req_t acc);
      out_req_t res;
      region_dec_t dec;
      logic [31:0] aligned;
      logic [1:0] lane;
      logic [4:0] be_shift;
      logic [4:0] le_shift;
      logic [7:0] lane_byte;
      logic [15:0] lane_half;
      logic [31:0] merged;
      logic is_store;
      res = '0;
      aligned = {acc.address[31:2], 2'b00};
      lane = acc.address[1:0];
      // big-endian lane: byte 0 sits in bits 31:24
      be_shift = {~lane, 3'b000};
      le_shift = {lane, 3'b000};
      is_store = (acc.operation == OP_SB || acc.operation == OP_SH ||
                  acc.operation == OP_SW);
      dec = is_store ? decode_store_region(aligned) : decode_load_region(aligned);
      res.region = dec.region;
      res.region_offset = dec.offset;
      if (dec.region == RG_NONE) begin
        res.fault = 1'b1;
      end else begin
        case (acc.operation)
          OP_LB, OP_LBU: begin
            lane_byte = acc.memory_word[be_shift +: 8];
            if (acc.operation == OP_LB) res.load_value = {{24{lane_byte[7]}}, lane_byte};
            else res.load_value = {24'd0, lane_byte};
          end
          OP_LH, OP_LHU: begin
            if (lane[0]) begin
              res.fault = 1'b1;
            end else begin
              lane_half = lane[1] ? acc.memory_word[15:0] : acc.memory_word[31:16];
              if (acc.operation == OP_LH) res.load_value = {{16{lane_half[15]}}, lane_half};
              else res.load_value = {16'd0, lane_half};
            end
          end
          OP_LW: begin
            if (lane != 2'd0) res.fault = 1'b1;
            else res.load_value = acc.memory_word;
          end
          OP_SB: begin
            if (dec.region == RG_PUTC) begin
              res.write_word = {24'd0, acc.store_data[7:0]} << le_shift;
            end else begin
              merged = acc.memory_word;
              merged[be_shift +: 8] = acc.store_data[7:0];
              res.write_word = merged;
            end
            res.write_enable = 1'b1;
          end
          OP_SH: begin
            if (lane[0]) begin
              res.fault = 1'b1;
            end else begin
              lane_half = acc.store_data[15:0];
              if (dec.region == RG_PUTC)
                res.write_word = {16'd0, lane_half} << le_shift;
              else if (lane[1])
                res.write_word = {acc.memory_word[31:16], lane_half};
              else
                res.write_word = {lane_half, acc.memory_word[15:0]};
              res.write_enable = 1'b1;
            end
          end
          default: begin
            if (lane != 2'd0) begin
              res.fault = 1'b1;
            end else begin
              res.write_word = acc.store_data;
              res.write_enable = 1'b1;
            end
          end
        endcase
      end
      if (is_store) stores_noted++;
      else loads_noted++;
      if (res.fault) faults_noted++;
      return res;
    endfunction

    function void note_request(in_req_t acc);
      pending_results.push_back(predict_access(acc));
      requests_noted++;
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_LIMIT)
          $display("ERROR: result with nothing pending: region=%0d off=%h load=%h wr=%h",
                   got.region, got.region_offset, got.load_value, got.write_word);
        return;
      end
      want = pending_results.pop_front();
      if (got.region !== want.region || got.region_offset !== want.region_offset ||
          got.load_value !== want.load_value || got.write_word !== want.write_word ||
          got.write_enable !== want.write_enable || got.fault !== want.fault) begin
        mismatches++;
        if (mismatches + unexpected <= REPORT_LIMIT) begin
          $display("ERROR: result %0d expected region=%0d off=%h load=%h wr=%h we=%b fault=%b",
                   results_checked, want.region, want.region_offset, want.load_value,
                   want.write_word, want.write_enable, want.fault);
          $display("       got                region=%0d off=%h load=%h wr=%h we=%b fault=%b",
                   got.region, got.region_offset, got.load_value, got.write_word,
                   got.write_enable, got.fault);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_data;

  access_scoreboard board = new();

  // Idle rates for the current phase, in percent; written by the main flow.
  int sender_idle_pct;
  int stall_pct;
  // Long receiver hold-offs: the main flow asks, the receiver counts them out.
  int hold_offs_asked;
  int hold_offs_done;
  int hold_off_left;
  int quiet_cycles;

  mips_load_store_lane_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Put every block input at a known value before the first edge.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_offs_asked = 0;
    hold_offs_done = 0;
    hold_off_left = 0;
    quiet_cycles = 0;
  end

  // Receiver: drive out_ready at the falling edge. A pending hold-off request
  // starts a long stretch with ready low; otherwise stall at the phase rate.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_offs_done != hold_offs_asked) begin
      hold_offs_done <= hold_offs_done + 1;
      hold_off_left <= HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: sample both handshakes at the rising edge. Note the request
  // before checking the result; the block cannot return it in the same cycle.
  // The watchdog ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, board.pending_results.size());
        $display("tb_mips_load_store_lane_unit NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_req_t make_access(logic [2:0] op, logic [31:0] addr,
                                          logic [31:0] sdat, logic [31:0] mem);
    in_req_t acc;
    acc.operation = op;
    acc.address = addr;
    acc.store_data = sdat;
    acc.memory_word = mem;
    return acc;
  endfunction

  // Offer one request: idle at the phase rate at falling edges, then raise
  // valid and hold it with the payload until the rising edge that takes it.
  task automatic send_request(input in_req_t acc);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return WORD_MASK;
      2: return 32'h8080_8080;
      default: return $urandom;
    endcase
  endfunction

  // Bias addresses toward the regions and their edges; the rest are arbitrary
  // words so that every address bit sees both values.
  function automatic logic [31:0] random_address();
    logic [31:0] edge_base;
    case ($urandom_range(9))
      0, 1: return INST_START + $urandom_range(0, INST_SIZE - 1);
      2, 3: return DATA_START + $urandom_range(0, DATA_SIZE - 1);
      4: return GETC_START + $urandom_range(0, 7);
      5: return $urandom_range(0, 15);
      6, 7: begin
        case ($urandom_range(6))
          0: edge_base = INST_START;
          1: edge_base = INST_START + INST_SIZE;
          2: edge_base = DATA_START;
          3: edge_base = DATA_START + DATA_SIZE;
          4: edge_base = GETC_START;
          5: edge_base = PUTC_START + PORT_BYTES;
          default: edge_base = 32'd0;
        endcase
        return edge_base + $urandom_range(0, 7) - 32'd4;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    // address zero, and sign and zero extension across byte lanes 0, 1, 3 and both halfword lanes
    send_request(make_access(OP_LW,  32'h0000_0000, 32'd0, 32'hA5A5_5A5A));
    send_request(make_access(OP_LB,  32'h0000_0003, 32'd0, 32'h0000_00FF));
    send_request(make_access(OP_LBU, INST_START, 32'd0, 32'h8012_3456));
    send_request(make_access(OP_LB,  INST_START + 32'd1, 32'd0, 32'h0080_0000));
    send_request(make_access(OP_LH,  INST_START + INST_SIZE - 32'd4, 32'd0, 32'h8001_7FFF));
    send_request(make_access(OP_LHU, DATA_START + 32'd2, 32'd0, 32'h1234_8765));
    send_request(make_access(OP_LH,  DATA_START + DATA_SIZE - 32'd2, 32'd0, 32'hFFFF_8000));
    // misaligned halfword, words with either low bit set, and a getc word load
    send_request(make_access(OP_LH,  DATA_START + 32'd1, 32'd0, WORD_MASK));
    send_request(make_access(OP_LW,  DATA_START + 32'd2, 32'd0, WORD_MASK));
    send_request(make_access(OP_LW,  DATA_START + 32'd1, 32'd0, WORD_MASK));
    send_request(make_access(OP_LW,  GETC_START, 32'd0, WORD_MASK));
    // bad regions for loads: putc, past the instruction region, top, near zero
    send_request(make_access(OP_LW,  PUTC_START, 32'd0, WORD_MASK));
    send_request(make_access(OP_LW,  INST_START + INST_SIZE, 32'd0, WORD_MASK));
    send_request(make_access(OP_LW,  32'hFFFF_FFFC, 32'd0, WORD_MASK));
    send_request(make_access(OP_LB,  32'h0000_0004, 32'd0, WORD_MASK));
    // stores into the data word: byte and halfword merges, whole and misaligned words
    send_request(make_access(OP_SB,  DATA_START, 32'h1234_56AB, WORD_MASK));
    send_request(make_access(OP_SB,  DATA_START + 32'd3, 32'h1234_56AB, 32'd0));
    send_request(make_access(OP_SH,  DATA_START + 32'd2, 32'hFFFF_8001, 32'd0));
    send_request(make_access(OP_SH,  DATA_START + DATA_SIZE - 32'd4, 32'h0000_FFFF, 32'd0));
    send_request(make_access(OP_SW,  DATA_START + DATA_SIZE - 32'd4, WORD_MASK, 32'd0));
    send_request(make_access(OP_SW,  DATA_START + 32'd2, WORD_MASK, 32'd0));
    // putc places lanes little-endian and ignores the memory word; last, a misaligned halfword
    send_request(make_access(OP_SB,  PUTC_START + 32'd2, 32'hFFFF_FFC3, 32'hDEAD_BEEF));
    send_request(make_access(OP_SH,  PUTC_START + 32'd2, 32'h1234_ABCD, 32'hDEAD_BEEF));
    send_request(make_access(OP_SW,  PUTC_START, 32'h0000_0041, 32'hDEAD_BEEF));
    send_request(make_access(OP_SH,  PUTC_START + 32'd3, 32'h1234_ABCD, 32'd0));
    // bad regions for stores: getc and instruction space
    send_request(make_access(OP_SB,  GETC_START, 32'h0000_0041, 32'd0));
    send_request(make_access(OP_SW,  INST_START, WORD_MASK, 32'd0));
  endtask

  // Main flow: reset, directed accesses, then random accesses through four
  // idling phases, with one long output hold-off while the sender keeps pushing.
  initial begin
    int sender_rates[NUM_PHASES];
    int stall_rates[NUM_PHASES];
    sender_rates = '{0, 85, 0, 8};
    stall_rates = '{0, 0, 85, 8};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      sender_idle_pct = sender_rates[phase];
      stall_pct = stall_rates[phase];
      for (int i = 0; i < ACCESSES_PER_PHASE; i++) begin
        // fill the block against a stalled output in the no-idle phase
        if (phase == 0 && i == ACCESSES_PER_PHASE / 2) hold_offs_asked = hold_offs_asked + 1;
        send_request(make_access(3'($urandom_range(7)), random_address(),
                                 random_word(), random_word()));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d loads, %0d stores, %0d faulting), %0d results checked,",
             board.requests_noted, board.loads_noted, board.stores_noted,
             board.faults_noted, board.results_checked);
    $display("over four idle/stall mixes and one %0d-cycle output hold-off.", HOLD_OFF_CYCLES);
    if (board.mismatches == 0 && board.unexpected == 0 &&
        board.pending_results.size() == 0) begin
      $display("tb_mips_load_store_lane_unit OK");
    end else begin
      $display("ERROR: %0d mismatches, %0d unexpected results, %0d results missing",
               board.mismatches, board.unexpected, board.pending_results.size());
      $display("tb_mips_load_store_lane_unit NOT OK");
    end
    $finish;
  end

endmodule
